[sv/arh_pkg.sv]
// ----------------------------------------------------------------------------
// arh_pkg: shared types and constants
// Sizes, command codes and the queue entry type of the density histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package arh_pkg;

  localparam int NUM_BINS    = 64;
  localparam int MAX_SAMPLES = 4096;

  localparam int BIN_W   = $clog2(NUM_BINS);
  localparam int ADDR_W  = $clog2(MAX_SAMPLES);
  localparam int TOTAL_W = $clog2(MAX_SAMPLES + 1);
  localparam int CNT_W   = 13;
  localparam int DATA_W  = 32;
  localparam int DENS_W  = 40;
  localparam int CTR_SH  = $clog2(2 * NUM_BINS);
  localparam int NUM_SH  = BIN_W + 16;
  localparam int NUM_W   = CNT_W + NUM_SH;
  localparam int NR_W    = TOTAL_W + DATA_W;
  localparam int DEN_W   = NR_W + DATA_W;

  localparam logic [DATA_W-1:0] VOL_RESET = 32'd2017837;
  localparam logic [DENS_W-1:0] DENS_MAX  = {DENS_W{1'b1}};

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] sample;
  } op_t;

endpackage

`default_nettype wire

[sv/arh_front.sv]
// ----------------------------------------------------------------------------
// arh_front: input stage
// Registers each accepted transaction and classifies it into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module arh_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             command,
  input  wire logic signed [arh_pkg::DATA_W-1:0] sample,
  output logic                                  op_valid,
  input  wire logic                             op_ready,
  output arh_pkg::op_t                          op
);
  import arh_pkg::*;

  logic take;

  assign in_ready = !op_valid || op_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (take) begin
      op_valid <= 1'b1;
    end else if (op_ready) begin
      op_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op.command <= (command == CMD_COMPUTE) ? CMD_COMPUTE : CMD_LOAD;
      // the sample of a compute is dont-care; zero it
      op.sample  <= (command == CMD_COMPUTE) ? '0 : sample;
    end
  end

endmodule

`default_nettype wire

[sv/arh_queue.sv]
// ----------------------------------------------------------------------------
// arh_queue: two-entry command queue
// Decouples the input stage from the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

module arh_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire arh_pkg::op_t push_op,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output arh_pkg::op_t      pop_op
);
  import arh_pkg::*;

  op_t        slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_op     = slot[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_op;
  end

endmodule

`default_nettype wire

[sv/arh_back.sv]
// ----------------------------------------------------------------------------
// arh_back: execution engine
// Stores samples, bins them by serial division and emits per-bin results.
// ----------------------------------------------------------------------------
`default_nettype none

module arh_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              op_valid,
  output logic                                   op_ready,
  input  wire arh_pkg::op_t                      op,
  input  wire logic [arh_pkg::DATA_W-1:0]        vol,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [arh_pkg::BIN_W-1:0]              bin_index,
  output logic signed [arh_pkg::DATA_W-1:0]      bin_center,
  output logic [arh_pkg::CNT_W-1:0]              bin_count,
  output logic [arh_pkg::DENS_W-1:0]             density,
  output logic                                   last
);
  import arh_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CLR    = 13'b0000000000010,
    S_DEN0   = 13'b0000000000100,
    S_DEN1   = 13'b0000000001000,
    S_DEN2   = 13'b0000000010000,
    S_RD     = 13'b0000000100000,
    S_DINIT  = 13'b0000001000000,
    S_DIV    = 13'b0000010000000,
    S_INC_RD = 13'b0000100000000,
    S_INC_WR = 13'b0001000000000,
    S_E_RD   = 13'b0010000000000,
    S_E_CALC = 13'b0100000000000,
    S_E_DIV  = 13'b1000000000000
  } state_t;

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  state_t state;
  logic   e_out;  // result pending load into the output register

  logic [TOTAL_W-1:0]       total;
  logic signed [DATA_W-1:0] rmin;
  logic signed [DATA_W-1:0] rmax;
  logic [DATA_W-1:0]        range;

  logic [DATA_W-1:0] store [MAX_SAMPLES];
  logic [DATA_W-1:0] st_rdata;
  logic [ADDR_W-1:0] si;

  logic [CNT_W-1:0] cnt_mem [NUM_BINS];
  logic [CNT_W-1:0] cnt_rdata;
  logic [BIN_W-1:0] cnt_raddr;
  logic [BIN_W-1:0] cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic             cnt_we;

  logic [BIN_W-1:0] ci;
  logic [BIN_W-1:0] bin_r;

  logic [NR_W-1:0]          nr;
  logic [2*DATA_W-1:0]      p_lo;
  logic [NR_W-DATA_W+DATA_W-1:0] p_hi;
  logic [DEN_W-1:0]         den;

  logic [DATA_W:0]   s_rem;
  logic [BIN_W:0]    s_q;
  logic [2:0]        s_step;

  logic [DEN_W:0]    e_rem;
  logic [DENS_W-1:0] e_q;
  logic [5:0]        e_step;
  logic [CNT_W-1:0]  e_cnt;
  logic [CTR_SH+DATA_W-1:0] cprod;

  logic signed [DATA_W:0] d_wide;
  logic [DATA_W-1:0]      d;
  logic [DATA_W:0]        s_r2;
  logic [BIN_W+1:0]       ceilv;
  logic [BIN_W+1:0]       binv;
  logic [BIN_W-1:0]       bin_c;
  logic [NUM_W-1:0]       num;
  logic [DEN_W:0]         e_r2;
  logic                   load_take;
  logic                   out_free;
  logic signed [DATA_W:0] ctr_wide;

  assign op_ready  = (state == S_IDLE) && !e_out;
  assign load_take = op_valid && op_ready && (op.command == CMD_LOAD);
  assign out_free  = !out_valid || out_ready;

  assign d_wide = {st_rdata[DATA_W-1], st_rdata} - {rmin[DATA_W-1], rmin};
  assign d      = d_wide[DATA_W-1:0];
  assign s_r2   = {s_rem[DATA_W-1:0], 1'b0};
  assign ceilv  = {1'b0, s_q} + {{(BIN_W+1){1'b0}}, (s_rem != '0)};
  assign binv   = ceilv - {{(BIN_W+1){1'b0}}, 1'b1};
  assign bin_c  = (binv > {2'b00, LAST_BIN}) ? LAST_BIN : binv[BIN_W-1:0];
  assign num    = {cnt_rdata, {NUM_SH{1'b0}}};
  assign e_r2   = {e_rem[DEN_W-1:0], 1'b0};
  assign ctr_wide = {rmin[DATA_W-1], rmin} + {1'b0, cprod[CTR_SH+DATA_W-1:CTR_SH]};

  // count memory ports
  always_comb begin
    cnt_raddr = (state == S_E_RD) ? ci : bin_c;
    cnt_we    = (state == S_CLR) || (state == S_INC_WR);
    cnt_waddr = (state == S_CLR) ? ci : bin_r;
    cnt_wdata = (state == S_CLR) ? '0 : cnt_rdata + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_take && (total < TOTAL_W'(MAX_SAMPLES))) store[total[ADDR_W-1:0]] <= op.sample;
    st_rdata <= store[si];
  end

  // load a pending result, drop the transaction once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_IDLE) && e_out && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      e_out     <= 1'b0;
      total     <= '0;
      rmin      <= '0;
      rmax      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (e_out && out_free) begin
            bin_index  <= ci;
            bin_center <= ctr_wide[DATA_W-1:0];
            bin_count  <= e_cnt;
            density    <= e_q;
            last       <= (ci == LAST_BIN);
            e_out      <= 1'b0;
            if (ci != LAST_BIN) begin
              ci    <= ci + BIN_W'(1);
              state <= S_E_RD;
            end
          end else if (op_valid && op_ready) begin
            if (op.command == CMD_COMPUTE) begin
              range <= DATA_W'(rmax - rmin);
              ci    <= '0;
              state <= S_CLR;
            end else if (total < TOTAL_W'(MAX_SAMPLES)) begin
              if (total == '0) begin
                rmin <= op.sample;
                rmax <= op.sample;
              end else begin
                if (op.sample < rmin) rmin <= op.sample;
                if (op.sample > rmax) rmax <= op.sample;
              end
              total <= total + TOTAL_W'(1);
            end
          end
        end
        S_CLR: begin
          ci <= ci + BIN_W'(1);
          if (ci == LAST_BIN) state <= S_DEN0;
        end
        S_DEN0: begin
          nr    <= NR_W'(total) * NR_W'(range);
          state <= S_DEN1;
        end
        S_DEN1: begin
          p_lo  <= nr[DATA_W-1:0] * vol;
          p_hi  <= nr[NR_W-1:DATA_W] * vol;
          state <= S_DEN2;
        end
        S_DEN2: begin
          den   <= DEN_W'(p_lo) + {p_hi, {DATA_W{1'b0}}};
          si    <= '0;
          ci    <= '0;
          state <= (total == '0) ? S_E_RD : S_RD;
        end
        S_RD: state <= S_DINIT;
        S_DINIT: begin
          s_step <= '0;
          if ((d == '0) || (range == '0)) begin
            // force bin zero: quotient 0, nonzero remainder
            s_q   <= '0;
            s_rem <= (DATA_W+1)'(1);
            state <= S_INC_RD;
          end else if (d >= range) begin
            s_q   <= (BIN_W+1)'(1);
            s_rem <= {1'b0, d - range};
            state <= S_DIV;
          end else begin
            s_q   <= '0;
            s_rem <= {1'b0, d};
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (s_r2 >= {1'b0, range}) begin
            s_rem <= s_r2 - {1'b0, range};
            s_q   <= {s_q[BIN_W-1:0], 1'b1};
          end else begin
            s_rem <= s_r2;
            s_q   <= {s_q[BIN_W-1:0], 1'b0};
          end
          s_step <= s_step + 3'd1;
          if (s_step == 3'(BIN_W - 1)) state <= S_INC_RD;
        end
        S_INC_RD: begin
          bin_r <= bin_c;
          state <= S_INC_WR;
        end
        S_INC_WR: begin
          si <= si + ADDR_W'(1);
          if (({1'b0, si} + TOTAL_W'(1)) == total) state <= S_E_RD;
          else state <= S_RD;
        end
        S_E_RD: state <= S_E_CALC;
        S_E_CALC: begin
          e_cnt  <= cnt_rdata;
          cprod  <= (CTR_SH+DATA_W)'({ci, 1'b1}) * (CTR_SH+DATA_W)'(range);
          e_step <= '0;
          e_rem  <= (DEN_W+1)'(num);
          if (cnt_rdata == '0) begin
            e_q   <= '0;
            e_out <= 1'b1;
            state <= S_IDLE;
          end else if ((den == '0) || (DEN_W'(num) >= den)) begin
            e_q   <= DENS_MAX;
            e_out <= 1'b1;
            state <= S_IDLE;
          end else begin
            e_q   <= '0;
            state <= S_E_DIV;
          end
        end
        S_E_DIV: begin
          if (e_r2 >= {1'b0, den}) begin
            e_rem <= e_r2 - {1'b0, den};
            e_q   <= {e_q[DENS_W-2:0], 1'b1};
          end else begin
            e_rem <= e_r2;
            e_q   <= {e_q[DENS_W-2:0], 1'b0};
          end
          e_step <= e_step + 6'd1;
          if (e_step == 6'(DENS_W - 1)) begin
            e_out <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TOTAL_W'(MAX_SAMPLES)) else $error("sample total overflow");
  a_last_bin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (bin_index == LAST_BIN)) else $error("last on wrong bin");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_E_DIV) |-> (e_rem < {1'b0, den})) else $error("density remainder too big");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !op_ready) else $error("command taken while busy");
`endif

endmodule

`default_nettype wire

[sv/auto_range_density_histogram.sv]
// ----------------------------------------------------------------------------
// auto_range_density_histogram: auto-ranging density histogram
// Loads Q16.16 samples, then on a compute emits 64 bins with density.
//
//   channel  dir  fields
//   in       in   command, sample
//   out      out  bin_index, bin_center, bin_count, density, last
//   cfg      in   volume_scale
//
// A load is taken by the engine in its idle state; the front stage and queue accept one
// transaction per cycle until the queue fills. A compute clears the counts and
// sets up the density denominator, bins each stored sample by serial division
// (with a shortcut when the sample sits at the minimum or the range is zero),
// and runs the 40-step density division per bin where it is needed. Reset is
// synchronous and clears the sample total, min and max; the sample store needs no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module auto_range_density_histogram (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               command,
  input  wire logic signed [arh_pkg::DATA_W-1:0]  sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [arh_pkg::BIN_W-1:0]               bin_index,
  output logic signed [arh_pkg::DATA_W-1:0]       bin_center,
  output logic [arh_pkg::CNT_W-1:0]               bin_count,
  output logic [arh_pkg::DENS_W-1:0]              density,
  output logic                                    last,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [arh_pkg::DATA_W-1:0]         volume_scale
);
  import arh_pkg::*;

  logic [DATA_W-1:0] vol;
  logic f_valid, f_ready, q_valid, q_ready;
  op_t  f_op, q_op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vol <= VOL_RESET;
    end else if (cfg_valid) begin
      vol <= volume_scale;
    end
  end

  arh_front u_front (
    .clk, .rst, .in_valid, .in_ready, .command, .sample,
    .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
  );

  arh_queue u_queue (
    .clk, .rst,
    .push_valid(f_valid), .push_ready(f_ready), .push_op(f_op),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_op(q_op)
  );

  arh_back u_back (
    .clk, .rst, .op_valid(q_valid), .op_ready(q_ready), .op(q_op), .vol,
    .out_valid, .out_ready, .bin_index, .bin_center, .bin_count, .density, .last
  );

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Density histogram testbench
// Loads signed sample sets, issues compute commands and checks every emitted
// bin against a behavioral histogram kept alongside, under random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class histo_board;
  logic signed [31:0] store[$];
  logic [31:0] vol;
  longint lo_v, hi_v;
  logic [5:0]  exp_index[$];
  logic [31:0] exp_center[$];
  logic [12:0] exp_count[$];
  logic [39:0] exp_density[$];
  logic        exp_last[$];
  int errors;

  function new();
    clear();
  endfunction

  function void clear();
    store.delete();
    vol = 32'd2017837;
    lo_v = 0;
    hi_v = 0;
    errors = 0;
  endfunction

  // count / (total * range/64/2^16 * vol) in Q0.40, saturating
  function logic [39:0] density_of(longint unsigned cnt, longint unsigned rng,
                                   longint unsigned tot);
    logic [127:0] num, den, q;
    if (cnt == 0) return 40'd0;
    if (rng == 0 || vol == 0 || tot == 0) return {40{1'b1}};
    num = 128'(cnt) * 64 * 65536;
    den = 128'(tot) * rng * vol;
    if (den <= num) return {40{1'b1}};
    q = (num << 40) / den;
    return q[39:0];
  endfunction

  function void note_input(logic cmd, logic signed [31:0] smp);
    longint rng, d, b;
    longint unsigned off;
    int counts[64];
    if (cmd == arh_pkg::CMD_LOAD) begin
      if (store.size() >= arh_pkg::MAX_SAMPLES) return;
      if (store.size() == 0) begin
        lo_v = smp;
        hi_v = smp;
      end else begin
        if (smp < lo_v) lo_v = smp;
        if (smp > hi_v) hi_v = smp;
      end
      store.push_back(smp);
      return;
    end
    rng = hi_v - lo_v;
    foreach (counts[i]) counts[i] = 0;
    foreach (store[i]) begin
      d = longint'(store[i]) - lo_v;
      b = 0;
      if (d != 0 && rng != 0) begin
        if (d > rng) d = rng;
        b = (d * 64 + rng - 1) / rng - 1;
        if (b > 63) b = 63;
      end
      counts[b]++;
    end
    for (int i = 0; i < 64; i++) begin
      off = ((2 * i + 1) * longint'(rng)) / 128;
      exp_index.push_back(i[5:0]);
      exp_center.push_back(32'(lo_v + longint'(off)));
      exp_count.push_back(counts[i][12:0]);
      exp_density.push_back(density_of(counts[i], rng, store.size()));
      exp_last.push_back(i == 63);
    end
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task check_bin(logic [5:0] idx, logic [31:0] ctr, logic [12:0] cnt,
                 logic [39:0] dens, logic lst);
    if (exp_index.size() == 0) begin
      report($sformatf("unexpected bin %0d", idx));
      return;
    end
    if (idx !== exp_index[0])
      report($sformatf("bin_index %0d, want %0d", idx, exp_index[0]));
    if (ctr !== exp_center[0])
      report($sformatf("bin %0d center %h, want %h", idx, ctr, exp_center[0]));
    if (cnt !== exp_count[0])
      report($sformatf("bin %0d count %0d, want %0d", idx, cnt, exp_count[0]));
    if (dens !== exp_density[0])
      report($sformatf("bin %0d density %h, want %h", idx, dens, exp_density[0]));
    if (lst !== exp_last[0])
      report($sformatf("bin %0d last %b, want %b", idx, lst, exp_last[0]));
    void'(exp_index.pop_front());
    void'(exp_center.pop_front());
    void'(exp_count.pop_front());
    void'(exp_density.pop_front());
    void'(exp_last.pop_front());
  endtask

  function int pending();
    return exp_index.size();
  endfunction
endclass

module testbench;
  import arh_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, command = 0;
  logic signed [31:0] sample = 0;
  logic out_valid, in_ready, out_ready = 0;
  logic [5:0] bin_index;
  logic signed [31:0] bin_center;
  logic [12:0] bin_count;
  logic [39:0] density;
  logic last;
  logic cfg_valid = 0, cfg_ready;
  logic [31:0] volume_scale = 0;

  histo_board board = new();

  auto_range_density_histogram DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .sample(sample), .out_valid(out_valid),
    .out_ready(out_ready), .bin_index(bin_index), .bin_center(bin_center),
    .bin_count(bin_count), .density(density), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .volume_scale(volume_scale)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid stays up between back-to-back transactions; drop it only for a gap
  task send(logic cmd, logic signed [31:0] smp);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    sample <= smp;
    do @(posedge clk); while (!in_ready);
    board.note_input(cmd, smp);
  endtask

  task write_volume(logic [31:0] v);
    in_valid <= 0;
    while (board.pending() != 0) @(posedge clk);
    // let the engine settle after the final bin
    repeat (50) @(posedge clk);
    cfg_valid <= 1;
    volume_scale <= v;
    do @(posedge clk); while (!cfg_ready);
    board.vol = v;
    cfg_valid <= 0;
  endtask

  function logic signed [31:0] rand_sample(int mode);
    logic signed [31:0] base;
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 4095)) - 2048;
      default: begin
        base = 32'sh0001_0000;
        return base + $signed($urandom_range(0, 255) << 12);
      end
    endcase
  endfunction

  // drain results with random backpressure
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        board.check_bin(bin_index, bin_center, bin_count, density, last);
      out_ready <= ($urandom_range(0, 99) < 70);
    end
  end

  initial begin
    int n, mode;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // empty store
    send(CMD_COMPUTE, 0);
    // single value, zero range
    send(CMD_LOAD, 32'sh7FFF_FFFF);
    send(CMD_LOAD, 32'sh7FFF_FFFF);
    send(CMD_COMPUTE, 0);
    // full-scale extremes
    send(CMD_LOAD, 32'sh8000_0000);
    send(CMD_LOAD, 32'sh0000_0000);
    send(CMD_LOAD, -32'sd1);
    send(CMD_LOAD, 32'sh5555_5555);
    send(CMD_LOAD, 32'shAAAA_AAAA);
    send(CMD_COMPUTE, 0);
    write_volume(32'd1);
    send(CMD_COMPUTE, 0);
    write_volume(32'hFFFF_FFFF);
    send(CMD_COMPUTE, 0);
    write_volume(32'd0);
    send(CMD_COMPUTE, 0);

    // fresh sets need a reset-free empty store: keep adding instead
    write_volume(32'd2017837);
    for (int ph = 0; ph < 4; ph++) begin
      n = $urandom_range(30, 40);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) send(CMD_LOAD, rand_sample(mode));
      send(CMD_COMPUTE, 0);
      if (ph == 1) write_volume($urandom_range(1, 1000));
      if (ph == 2) write_volume($urandom());
    end
    in_valid <= 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
